// File: src/sesc_pkg.sv
// Package of shared types and constants for the servo endpoint slew controller.
`default_nettype none
package sesc_pkg;

    localparam int NUM_SERVOS_DEF = 2;

    localparam int CMD_W   = 2;
    localparam int SEL_W   = 3;
    localparam int WIDTH_W = 16;
    localparam int STEP_W  = 12;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 16;
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 8;
    localparam int M_DATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WIDEN  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NARROW = 2'd3;

    localparam logic [IDX_W-1:0] REG_MOVE_STEP    = 2'd0;
    localparam logic [IDX_W-1:0] REG_LIMIT_STEP   = 2'd1;
    localparam logic [IDX_W-1:0] REG_ABSOLUTE_MIN = 2'd2;
    localparam logic [IDX_W-1:0] REG_ABSOLUTE_MAX = 2'd3;

    localparam logic [STEP_W-1:0]  MOVE_STEP_RST    = 12'd1;
    localparam logic [STEP_W-1:0]  LIMIT_STEP_RST   = 12'd10;
    localparam logic [WIDTH_W-1:0] ABSOLUTE_MIN_RST = 16'd500;
    localparam logic [WIDTH_W-1:0] ABSOLUTE_MAX_RST = 16'd2500;
    localparam logic [WIDTH_W-1:0] DEFAULT_LOWER    = 16'd1000;
    localparam logic [WIDTH_W-1:0] DEFAULT_UPPER    = 16'd2000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_TOGGLE,
        ST_ADJ_CALC,
        ST_ADJ_APPLY
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_TOGGLE,
        OP_ADJ_CALC,
        OP_ADJ_APPLY
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [2:0] idx;
        logic       widen;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

// File: src/servo_endpoint_slew_controller.sv
// Top level of the servo endpoint slew controller: controller plus datapath.
// Tick: the controller enters the tick state on the accepting edge, then issues one report per cycle while
//   the sink is ready; the servo walk in the controller covers servos 0 to NUM_SERVOS-1 in order.
// Toggle passes through the toggle state, widen and narrow through calculate, then apply, to ready again.
// A new transaction is accepted while the last report still waits in the output register.
// Synchronous active-low reset restores state, configuration and servo registers and output valid.
`default_nettype none
module servo_endpoint_slew_controller #(
    parameter int NUM_SERVOS = sesc_pkg::NUM_SERVOS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [sesc_pkg::S_DATA_W-1:0]   s_axis_tdata,  // [2:0] servo_select
    input  wire logic [sesc_pkg::S_USER_W-1:0]   s_axis_tuser,  // [1:0] cmd
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [2:0] servo_number, [18:3] pulse_width, [19] at_lower_led, [20] at_upper_led
    output logic [sesc_pkg::M_DATA_W-1:0]        m_axis_tdata,
    output logic                                 m_axis_tlast,  // last_report
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [sesc_pkg::IDX_W-1:0]      i_cfg_index,
    input  wire logic [sesc_pkg::CFG_W-1:0]      i_cfg_data
);

    sesc_pkg::t_dp_cmd    dp_cmd;
    sesc_pkg::t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    sesc_ctrl #(
        .NUM_SERVOS(NUM_SERVOS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser[sesc_pkg::CMD_W-1:0]),
        .i_in_sel   (s_axis_tdata[sesc_pkg::SEL_W-1:0]),
        .o_in_ready (s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    sesc_datapath #(
        .NUM_SERVOS(NUM_SERVOS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// File: src/sesc_ctrl.sv
// Controller state machine: sequences ticks, toggles and endpoint adjustments.
`default_nettype none
module sesc_ctrl #(
    parameter int NUM_SERVOS = sesc_pkg::NUM_SERVOS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [sesc_pkg::CMD_W-1:0]  i_in_cmd,
    input  wire logic [sesc_pkg::SEL_W-1:0]  i_in_sel,
    output logic                             o_in_ready,
    input  wire sesc_pkg::t_dp_status        i_status,
    output sesc_pkg::t_dp_cmd                o_cmd
);

    localparam int IdxW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SERVOS - 1);

    sesc_pkg::t_state r_state, n_state;
    logic [IdxW-1:0]  r_idx, n_idx;
    logic             r_widen, n_widen;
    logic             r_recent_valid, n_recent_valid;
    logic [IdxW-1:0]  r_recent, n_recent;
    logic             in_accept;
    logic             sel_ok;
    logic             idx_last;

    assign in_accept = i_in_valid && (r_state == sesc_pkg::ST_IDLE);
    assign sel_ok    = ({1'b0, i_in_sel} < (sesc_pkg::SEL_W + 1)'(NUM_SERVOS));
    assign idx_last  = (r_idx == LastIdx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= sesc_pkg::ST_IDLE;
            r_idx          <= '0;
            r_widen        <= 1'b0;
            r_recent_valid <= 1'b0;
            r_recent       <= '0;
        end else begin
            r_state        <= n_state;
            r_idx          <= n_idx;
            r_widen        <= n_widen;
            r_recent_valid <= n_recent_valid;
            r_recent       <= n_recent;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_widen        = r_widen;
        n_recent_valid = r_recent_valid;
        n_recent       = r_recent;
        case (r_state)
            sesc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    case (i_in_cmd)
                        sesc_pkg::CMD_TICK: begin
                            n_state = sesc_pkg::ST_TICK;
                            n_idx   = '0;
                        end
                        sesc_pkg::CMD_TOGGLE: begin
                            if (sel_ok) begin
                                n_state = sesc_pkg::ST_TOGGLE;
                                n_idx   = i_in_sel[IdxW-1:0];
                            end
                        end
                        default: begin
                            if (r_recent_valid) begin
                                n_state = sesc_pkg::ST_ADJ_CALC;
                                n_idx   = r_recent;
                                n_widen = (i_in_cmd == sesc_pkg::CMD_WIDEN);
                            end
                        end
                    endcase
                end
            end
            sesc_pkg::ST_TICK: begin
                if (i_status.out_free) begin
                    if (idx_last) begin
                        n_state = sesc_pkg::ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            sesc_pkg::ST_TOGGLE: begin
                n_recent       = r_idx;
                n_recent_valid = 1'b1;
                n_state        = sesc_pkg::ST_IDLE;
            end
            sesc_pkg::ST_ADJ_CALC: begin
                n_state = sesc_pkg::ST_ADJ_APPLY;
            end
            sesc_pkg::ST_ADJ_APPLY: begin
                n_state = sesc_pkg::ST_IDLE;
            end
            default: begin
                n_state = sesc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == sesc_pkg::ST_IDLE);
        o_cmd.op    = sesc_pkg::OP_NONE;
        o_cmd.idx   = 3'(r_idx);
        o_cmd.widen = r_widen;
        o_cmd.last  = idx_last;
        case (r_state)
            sesc_pkg::ST_TICK: begin
                if (i_status.out_free) begin
                    o_cmd.op = sesc_pkg::OP_TICK;
                end
            end
            sesc_pkg::ST_TOGGLE:    o_cmd.op = sesc_pkg::OP_TOGGLE;
            sesc_pkg::ST_ADJ_CALC:  o_cmd.op = sesc_pkg::OP_ADJ_CALC;
            sesc_pkg::ST_ADJ_APPLY: o_cmd.op = sesc_pkg::OP_ADJ_APPLY;
            default:                o_cmd.op = sesc_pkg::OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

// File: src/sesc_datapath.sv
// Datapath: servo state, configuration registers, slew and endpoint arithmetic, output register.
`default_nettype none
module sesc_datapath #(
    parameter int NUM_SERVOS = sesc_pkg::NUM_SERVOS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [sesc_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [sesc_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire sesc_pkg::t_dp_cmd              i_cmd,
    output sesc_pkg::t_dp_status                o_status,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [sesc_pkg::M_DATA_W-1:0]       o_out_data,
    output logic                                o_out_last
);

    localparam int IdxW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
    localparam int WW   = sesc_pkg::WIDTH_W;

    logic [sesc_pkg::STEP_W-1:0] r_move_step;
    logic [sesc_pkg::STEP_W-1:0] r_limit_step;
    logic [WW-1:0]               r_abs_min;
    logic [WW-1:0]               r_abs_max;

    logic [WW-1:0] r_cur [NUM_SERVOS];
    logic [WW-1:0] r_tgt [NUM_SERVOS];
    logic [WW-1:0] r_lo  [NUM_SERVOS];
    logic [WW-1:0] r_hi  [NUM_SERVOS];

    logic [WW-1:0] r_adj_n;
    logic          r_adj_on_lo;
    logic          r_adj_on_hi;

    logic          r_out_valid;
    logic [2:0]    r_out_servo;
    logic [WW-1:0] r_out_width;
    logic          r_out_at_lo;
    logic          r_out_at_hi;
    logic          r_out_last;

    logic [IdxW-1:0] idx;
    logic [WW-1:0]   e_cur, e_tgt, e_lo, e_hi;
    logic [WW-1:0]   move16, limit16;
    logic [WW-1:0]   diff_up, diff_dn, nc;
    logic            nc_at_lo, nc_at_hi;
    logic            on_lo, on_hi, go_up;
    logic [WW-1:0]   base;
    logic [WW:0]     sum17;
    logic [WW-1:0]   up_sat, up_n, dn_sat, dn_n, adj_n;

    assign idx   = i_cmd.idx[IdxW-1:0];
    assign e_cur = r_cur[idx];
    assign e_tgt = r_tgt[idx];
    assign e_lo  = r_lo[idx];
    assign e_hi  = r_hi[idx];

    assign move16  = WW'(r_move_step);
    assign limit16 = WW'(r_limit_step);

    always_comb begin
        diff_up = e_tgt - e_cur;
        diff_dn = e_cur - e_tgt;
        if (e_cur < e_tgt) begin
            nc = (diff_up <= move16) ? e_tgt : e_cur + move16;
        end else if (e_cur > e_tgt) begin
            nc = (diff_dn <= move16) ? e_tgt : e_cur - move16;
        end else begin
            nc = e_cur;
        end
    end

    assign nc_at_lo = (nc == e_lo);
    assign nc_at_hi = !nc_at_lo && (nc == e_hi);

    always_comb begin
        on_lo  = (e_tgt == e_lo);
        on_hi  = !on_lo && (e_tgt == e_hi);
        go_up  = on_lo ? !i_cmd.widen : i_cmd.widen;
        base   = on_lo ? e_lo : e_hi;
        sum17  = {1'b0, base} + {1'b0, limit16};
        up_sat = sum17[WW] ? {WW{1'b1}} : sum17[WW-1:0];
        up_n   = (up_sat > r_abs_max) ? r_abs_max : up_sat;
        dn_sat = (base > limit16) ? (base - limit16) : '0;
        dn_n   = (dn_sat < r_abs_min) ? r_abs_min : dn_sat;
        adj_n  = go_up ? up_n : dn_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_step  <= sesc_pkg::MOVE_STEP_RST;
            r_limit_step <= sesc_pkg::LIMIT_STEP_RST;
            r_abs_min    <= sesc_pkg::ABSOLUTE_MIN_RST;
            r_abs_max    <= sesc_pkg::ABSOLUTE_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sesc_pkg::REG_MOVE_STEP:    r_move_step  <= i_cfg_data[sesc_pkg::STEP_W-1:0];
                sesc_pkg::REG_LIMIT_STEP:   r_limit_step <= i_cfg_data[sesc_pkg::STEP_W-1:0];
                sesc_pkg::REG_ABSOLUTE_MIN: r_abs_min    <= i_cfg_data;
                sesc_pkg::REG_ABSOLUTE_MAX: r_abs_max    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SERVOS; i++) begin
                r_cur[i] <= sesc_pkg::DEFAULT_LOWER;
                r_tgt[i] <= sesc_pkg::DEFAULT_LOWER;
                r_lo[i]  <= sesc_pkg::DEFAULT_LOWER;
                r_hi[i]  <= sesc_pkg::DEFAULT_UPPER;
            end
        end else begin
            case (i_cmd.op)
                sesc_pkg::OP_TICK: begin
                    r_cur[idx] <= nc;
                end
                sesc_pkg::OP_TOGGLE: begin
                    r_tgt[idx] <= (e_tgt == e_hi) ? e_lo : e_hi;
                end
                sesc_pkg::OP_ADJ_APPLY: begin
                    if (r_adj_on_lo && (r_adj_n < e_hi)) begin
                        r_lo[idx]  <= r_adj_n;
                        r_tgt[idx] <= r_adj_n;
                    end else if (r_adj_on_hi && (r_adj_n > e_lo)) begin
                        r_hi[idx]  <= r_adj_n;
                        r_tgt[idx] <= r_adj_n;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == sesc_pkg::OP_ADJ_CALC) begin
            r_adj_n     <= adj_n;
            r_adj_on_lo <= on_lo;
            r_adj_on_hi <= on_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == sesc_pkg::OP_TICK) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == sesc_pkg::OP_TICK) begin
            r_out_servo <= i_cmd.idx;
            r_out_width <= nc;
            r_out_at_lo <= nc_at_lo;
            r_out_at_hi <= nc_at_hi;
            r_out_last  <= i_cmd.last;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = {3'b000, r_out_at_hi, r_out_at_lo, r_out_width, r_out_servo};
    assign o_out_last  = r_out_last;

endmodule
`default_nettype wire

// File: src/sesc_checker.sv
// Port-level checker for the servo endpoint slew controller, bound to the top level.
`default_nettype none
module sesc_checker #(
    parameter int NUM_SERVOS = sesc_pkg::NUM_SERVOS_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic [sesc_pkg::S_USER_W-1:0] s_axis_tuser,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [sesc_pkg::M_DATA_W-1:0] m_axis_tdata,
    input wire logic                          m_axis_tlast
);

    localparam logic [2:0] LastServo = 3'(NUM_SERVOS - 1);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled output transaction changed");

    a_no_accept_mid_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted while a tick is still reporting");

    a_last_is_final_servo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata[2:0] == LastServo))
        else $error("last report not for the final servo");

    a_no_report_from_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready
            && (s_axis_tuser[sesc_pkg::CMD_W-1:0] != sesc_pkg::CMD_TICK)
        |=> !$rose(m_axis_tvalid))
        else $error("report produced by a non-tick transaction");

endmodule

bind servo_endpoint_slew_controller sesc_checker #(
    .NUM_SERVOS(NUM_SERVOS)
) u_sesc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the servo endpoint slew controller.
`timescale 1ns / 100ps
module tb;

    localparam int NSERVO = sesc_pkg::NUM_SERVOS_DEF;

    typedef struct packed {
        logic [sesc_pkg::CMD_W-1:0] cmd;
        logic [sesc_pkg::SEL_W-1:0] sel;
    } t_cmd_item;

    typedef struct packed {
        logic [2:0]                   servo;
        logic [sesc_pkg::WIDTH_W-1:0] width;
        logic                         at_lo;
        logic                         at_hi;
        logic                         last;
    } t_report;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [sesc_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;  // [2:0] servo_select
    logic [sesc_pkg::S_USER_W-1:0]   s_axis_tuser = '0;  // [1:0] cmd
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [2:0] servo_number, [18:3] pulse_width, [19] at_lower_led, [20] at_upper_led
    logic [sesc_pkg::M_DATA_W-1:0]   m_axis_tdata;
    logic                            m_axis_tlast;       // last_report
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [sesc_pkg::IDX_W-1:0]      i_cfg_index = '0;
    logic [sesc_pkg::CFG_W-1:0]      i_cfg_data = '0;

    // servo state as predicted
    logic [sesc_pkg::WIDTH_W-1:0] pos_w  [NSERVO];
    logic [sesc_pkg::WIDTH_W-1:0] goal_w [NSERVO];
    logic [sesc_pkg::WIDTH_W-1:0] end_lo [NSERVO];
    logic [sesc_pkg::WIDTH_W-1:0] end_hi [NSERVO];
    logic                         toggled_any;
    logic [2:0]                   toggled_servo;
    logic [sesc_pkg::STEP_W-1:0]  slew_step;
    logic [sesc_pkg::STEP_W-1:0]  trim_step;
    logic [sesc_pkg::WIDTH_W-1:0] floor_w;
    logic [sesc_pkg::WIDTH_W-1:0] ceil_w;

    t_cmd_item pending_cmds[$];
    t_report   expected_reports[$];

    logic cmd_fire = 1'b0;
    int   mismatches = 0;
    int   n_queued = 0;
    int   n_ticks = 0;
    int   n_toggles = 0;
    int   n_trims = 0;
    int   n_reports = 0;
    int   n_reg_writes = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    logic [15:0] stall_pat = 16'hFFFF;
    int   pat_pos = 0;
    int   pat_left = 0;

    servo_endpoint_slew_controller #(
        .NUM_SERVOS(NSERVO)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int trim_down(input int v);
        int n;
        n = (v > trim_step) ? v - trim_step : 0;
        if (n < floor_w) n = floor_w;
        return n;
    endfunction

    function automatic int trim_up(input int v);
        int n;
        n = v + trim_step;
        if (n > 65535) n = 65535;
        if (n > ceil_w) n = ceil_w;
        return n;
    endfunction

    function automatic void predict_command(input logic [sesc_pkg::CMD_W-1:0] cmd,
                                            input logic [sesc_pkg::SEL_W-1:0] sel);
        int      c;
        int      t;
        int      n;
        int      s;
        int      i;
        logic    outward;
        t_report r;
        case (cmd)
            sesc_pkg::CMD_TICK: begin
                n_ticks++;
                for (i = 0; i < NSERVO; i++) begin
                    c = pos_w[i];
                    t = goal_w[i];
                    if (c < t) begin
                        c = (t - c <= slew_step) ? t : c + slew_step;
                    end else if (c > t) begin
                        c = (c - t <= slew_step) ? t : c - slew_step;
                    end
                    pos_w[i] = 16'(c);
                    r.servo = 3'(i);
                    r.width = pos_w[i];
                    r.at_lo = (pos_w[i] == end_lo[i]);
                    r.at_hi = !r.at_lo && (pos_w[i] == end_hi[i]);
                    r.last  = (i == NSERVO - 1);
                    expected_reports.push_back(r);
                end
            end
            sesc_pkg::CMD_TOGGLE: begin
                n_toggles++;
                if (sel < NSERVO) begin
                    goal_w[sel] = (goal_w[sel] == end_hi[sel]) ? end_lo[sel] : end_hi[sel];
                    toggled_servo = sel;
                    toggled_any = 1'b1;
                end
            end
            default: begin
                n_trims++;
                if (toggled_any && toggled_servo < NSERVO) begin
                    s = toggled_servo;
                    outward = (cmd == sesc_pkg::CMD_WIDEN);
                    if (goal_w[s] == end_lo[s]) begin
                        n = outward ? trim_down(end_lo[s]) : trim_up(end_lo[s]);
                        if (n < end_hi[s]) begin
                            end_lo[s] = 16'(n);
                            goal_w[s] = 16'(n);
                        end
                    end else if (goal_w[s] == end_hi[s]) begin
                        n = outward ? trim_up(end_hi[s]) : trim_down(end_hi[s]);
                        if (n > end_lo[s]) begin
                            end_hi[s] = 16'(n);
                            goal_w[s] = 16'(n);
                        end
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // sample both streams and the register channel
    always @(posedge i_clk) begin : watch_ports
        t_report want;
        if (!i_rst_n) begin
            cmd_fire <= 1'b0;
        end else begin
            cmd_fire <= s_axis_tvalid && s_axis_tready;
            if (i_cfg_valid && o_cfg_ready) begin
                n_reg_writes++;
                case (i_cfg_index)
                    sesc_pkg::REG_MOVE_STEP:    slew_step = i_cfg_data[sesc_pkg::STEP_W-1:0];
                    sesc_pkg::REG_LIMIT_STEP:   trim_step = i_cfg_data[sesc_pkg::STEP_W-1:0];
                    sesc_pkg::REG_ABSOLUTE_MIN: floor_w = i_cfg_data;
                    sesc_pkg::REG_ABSOLUTE_MAX: ceil_w = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_command(s_axis_tuser[sesc_pkg::CMD_W-1:0],
                                s_axis_tdata[sesc_pkg::SEL_W-1:0]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                n_reports++;
                if (expected_reports.size() == 0) begin
                    $error("unexpected servo report: servo %0d width %0d",
                           m_axis_tdata[2:0], m_axis_tdata[18:3]);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("servo_number", 16'(want.servo), 16'(m_axis_tdata[2:0]));
                    check_field("pulse_width", want.width, m_axis_tdata[18:3]);
                    check_field("at_lower_led", 16'(want.at_lo), 16'(m_axis_tdata[19]));
                    check_field("at_upper_led", 16'(want.at_hi), 16'(m_axis_tdata[20]));
                    check_field("last_report", 16'(want.last), 16'(m_axis_tlast));
                end
            end
        end
    end

    // present commands in bursts with random gaps
    always @(negedge i_clk) begin : drive_cmds
        t_cmd_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || cmd_fire) begin
            if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                nxt = pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(sesc_pkg::S_DATA_W-sesc_pkg::SEL_W){1'b0}}, nxt.sel};
                s_axis_tuser  <= {{(sesc_pkg::S_USER_W-sesc_pkg::CMD_W){1'b0}}, nxt.cmd};
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // stall the report stream on a changing pattern
    always @(negedge i_clk) begin : drive_ready
        if (pat_left == 0) begin
            stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                    : (16'($urandom()) | 16'h0001);
            pat_left = $urandom_range(20, 200);
            pat_pos = 0;
        end
        m_axis_tready <= stall_pat[pat_pos];
        pat_pos = (pat_pos + 1) % 16;
        pat_left--;
    end

    function automatic void push_cmd(input logic [sesc_pkg::CMD_W-1:0] cmd,
                                     input logic [sesc_pkg::SEL_W-1:0] sel);
        t_cmd_item it;
        it.cmd = cmd;
        it.sel = sel;
        pending_cmds.push_back(it);
        n_queued++;
    endfunction

    function automatic logic [sesc_pkg::CMD_W-1:0] pick_trim();
        return $urandom_range(0, 1) ? sesc_pkg::CMD_WIDEN : sesc_pkg::CMD_NARROW;
    endfunction

    function automatic void queue_random_cmds(input int count);
        int stop_at;
        stop_at = n_queued + count;
        while (n_queued < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                push_cmd(sesc_pkg::CMD_TOGGLE, 3'($urandom_range(0, NSERVO - 1)));
                repeat ($urandom_range(1, 5)) begin
                    push_cmd(sesc_pkg::CMD_TICK, 3'($urandom_range(0, 7)));
                end
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(8, 20)
                                                    : $urandom_range(0, 5)) begin
                    push_cmd(pick_trim(), 3'($urandom_range(0, 7)));
                end
                repeat ($urandom_range(0, 3)) begin
                    push_cmd(sesc_pkg::CMD_TICK, 3'($urandom_range(0, 7)));
                end
            end else begin
                push_cmd(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
            end
        end
    endfunction

    task automatic write_reg(input logic [sesc_pkg::IDX_W-1:0] idx,
                             input logic [sesc_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input int slew, input int trim, input int lo, input int hi);
        write_reg(sesc_pkg::REG_MOVE_STEP, 16'(slew));
        write_reg(sesc_pkg::REG_LIMIT_STEP, 16'(trim));
        write_reg(sesc_pkg::REG_ABSOLUTE_MIN, 16'(lo));
        write_reg(sesc_pkg::REG_ABSOLUTE_MAX, 16'(hi));
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    initial begin : run_test
        int p;
        int lo;
        int hi;
        int t;
        for (p = 0; p < NSERVO; p++) begin
            pos_w[p]  = sesc_pkg::DEFAULT_LOWER;
            goal_w[p] = sesc_pkg::DEFAULT_LOWER;
            end_lo[p] = sesc_pkg::DEFAULT_LOWER;
            end_hi[p] = sesc_pkg::DEFAULT_UPPER;
        end
        toggled_any   = 1'b0;
        toggled_servo = '0;
        slew_step     = sesc_pkg::MOVE_STEP_RST;
        trim_step     = sesc_pkg::LIMIT_STEP_RST;
        floor_w       = sesc_pkg::ABSOLUTE_MIN_RST;
        ceil_w        = sesc_pkg::ABSOLUTE_MAX_RST;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // endpoint moves before any toggle, missing servos, both directions
        push_cmd(sesc_pkg::CMD_WIDEN, 3'd0);
        push_cmd(sesc_pkg::CMD_NARROW, 3'd7);
        push_cmd(sesc_pkg::CMD_TOGGLE, 3'd7);
        push_cmd(sesc_pkg::CMD_WIDEN, 3'd0);
        push_cmd(sesc_pkg::CMD_TICK, 3'd0);
        push_cmd(sesc_pkg::CMD_TOGGLE, 3'd0);
        push_cmd(sesc_pkg::CMD_TICK, 3'd7);
        push_cmd(sesc_pkg::CMD_TOGGLE, 3'd1);
        push_cmd(sesc_pkg::CMD_NARROW, 3'd0);
        push_cmd(sesc_pkg::CMD_WIDEN, 3'd0);
        push_cmd(sesc_pkg::CMD_TICK, 3'd0);
        push_cmd(sesc_pkg::CMD_TOGGLE, 3'd1);
        push_cmd(sesc_pkg::CMD_WIDEN, 3'd0);
        push_cmd(sesc_pkg::CMD_NARROW, 3'd0);
        push_cmd(sesc_pkg::CMD_NARROW, 3'd0);
        push_cmd(sesc_pkg::CMD_TOGGLE, 3'd2);
        push_cmd(sesc_pkg::CMD_TOGGLE, 3'd3);
        push_cmd(sesc_pkg::CMD_TOGGLE, 3'd4);
        push_cmd(sesc_pkg::CMD_TOGGLE, 3'd5);
        push_cmd(sesc_pkg::CMD_TOGGLE, 3'd6);
        push_cmd(sesc_pkg::CMD_WIDEN, 3'd0);
        push_cmd(sesc_pkg::CMD_TICK, 3'd0);
        wait_drained();

        for (p = 0; p < 9; p++) begin
            case (p)
                0: set_regs(4095, 4095, 0, 65535);
                1: set_regs(1, 1, 0, 65535);
                2: set_regs(0, 4095, 65535, 0);
                3: set_regs(4095, 1, 0, 0);
                4: set_regs(2048, 2730, 65535, 65535);
                default: begin
                    lo = $urandom_range(0, 1500);
                    hi = $urandom_range(1500, 65535);
                    if ($urandom_range(0, 4) == 0) begin
                        t = lo;
                        lo = hi;
                        hi = t;
                    end
                    set_regs(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                         : $urandom_range(100, 1200),
                             ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4095)
                                                         : $urandom_range(1, 300),
                             lo, hi);
                end
            endcase
            queue_random_cmds(45);
            wait_drained();
        end

        repeat (12) @(posedge i_clk);
        $display("Covered %0d commands: %0d ticks, %0d toggles, %0d endpoint trims",
                 n_ticks + n_toggles + n_trims, n_ticks, n_toggles, n_trims);
        $display("Checked %0d servo reports across %0d register writes",
                 n_reports, n_reg_writes);
        if (mismatches == 0) begin
            $display("servo_endpoint_slew_controller: match");
        end else begin
            $display("servo_endpoint_slew_controller: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #(10_000_000);
        $display("servo_endpoint_slew_controller: mismatch");
        $finish;
    end

endmodule
